[rtl/keyed_lifo_stack_with_purge_top_assert.svh]
// ----------------------------------------------------------------------------
// Keyed LIFO stack assertion macros
// Shorthand for the concurrent checks on the stack's stream ports.
// ----------------------------------------------------------------------------
`ifndef KEYED_LIFO_STACK_WITH_PURGE_TOP_ASSERT_SVH
`define KEYED_LIFO_STACK_WITH_PURGE_TOP_ASSERT_SVH

// same-cycle implication
`define KLPS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("keyed lifo stack check failed");

// next-cycle implication
`define KLPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("keyed lifo stack check failed");

`endif

[rtl/klps_pkg.sv]
// ----------------------------------------------------------------------------
// Keyed LIFO stack package
// Shared codes, widths and types of the keyed LIFO stack.
// ----------------------------------------------------------------------------
`default_nettype none

package klps_pkg;

  localparam int unsigned KeyW      = 64;
  localparam int unsigned PayW      = 64;
  localparam int unsigned OpW       = 2;
  localparam int unsigned StatW     = 2;
  localparam int unsigned RemCntW   = 7;
  localparam int unsigned InDataW   = KeyW + PayW;
  localparam int unsigned OutDataW  = ((KeyW + PayW + RemCntW + 7) / 8) * 8;
  localparam int unsigned DefDepth  = 64;

  localparam logic [OpW-1:0] OP_PUSH   = 2'd0;
  localparam logic [OpW-1:0] OP_POP    = 2'd1;
  localparam logic [OpW-1:0] OP_REMOVE = 2'd2;

  localparam logic [StatW-1:0] ST_DONE    = 2'd0;
  localparam logic [StatW-1:0] ST_NOMATCH = 2'd1;
  localparam logic [StatW-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [PayW-1:0] payload;
    logic [KeyW-1:0] key;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic from_head;
  } chain_ctl_t;

endpackage

`default_nettype wire

[rtl/keyed_lifo_stack_with_purge_top.sv]
// ----------------------------------------------------------------------------
// Keyed LIFO stack with purge
// Bounded stack of key and payload entries with push, keyed pop and purge.
// ----------------------------------------------------------------------------
// Entries live in a chain of DEPTH cells, oldest in cell 0. A push loads the
// next free cell directly. Pop and remove stream the n held entries through
// cell 0, one per cycle, past a single key comparator and re-insert the kept
// ones behind the rest: remove makes one pass, pop makes one pass to locate the
// newest match and a second to close the gap, or only the first when nothing
// matches, and an unknown request or an empty stack goes straight to the answer.
// Requests are taken one at a time, and only while the output register is
// empty or being read; a stalled response holds the block until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_lifo_stack_with_purge_top #(
  parameter int unsigned DEPTH = klps_pkg::DefDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // match_key [63:0], entry_payload [127:64]
  input  wire logic [klps_pkg::InDataW-1:0]  s_axis_tdata_i,
  // operation [1:0]
  input  wire logic [klps_pkg::OpW-1:0]      s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // popped_key [63:0], popped_payload [127:64], removed_count [134:128]
  output logic [klps_pkg::OutDataW-1:0]      m_axis_tdata_o,
  // status [1:0]
  output logic [klps_pkg::StatW-1:0]         m_axis_tuser_o
);
  import klps_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {StIdle, StScan, StCompact, StDone} state_e;

  state_e              state_q;
  logic [OpW-1:0]      op_q;
  logic [KeyW-1:0]     key_q;
  logic [CW-1:0]       cnt_q;
  logic [CW-1:0]       n_q;
  logic [CW-1:0]       rem_q;
  logic [IW-1:0]       step_q;
  logic [IW-1:0]       ins_q;
  logic [IW-1:0]       pos_q;
  logic                found_q;
  entry_t              cap_q;
  logic                ov_q;
  logic [OutDataW-1:0] odata_q;
  logic [StatW-1:0]    ouser_q;

  entry_t     head_ent;
  entry_t     push_ent;
  chain_ctl_t ctl;
  logic [IW-1:0] load_idx;
  logic       in_fire;
  logic       out_free;
  logic       out_load;
  logic       head_match;
  logic       last_step;
  logic       drop;
  logic [KeyW-1:0] in_key;
  logic [CW-1:0]   rem_next;

  assign in_key   = s_axis_tdata_i[KeyW-1:0];
  assign push_ent = '{payload: s_axis_tdata_i[InDataW-1:KeyW], key: in_key};

  assign out_free        = !ov_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == StIdle) && out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (in_fire && (s_axis_tuser_i == OP_PUSH)) ||
                           ((state_q == StDone) && out_free);

  assign head_match = (key_q == '0) || (head_ent.key == key_q);
  assign last_step  = (CW'(step_q) + CW'(1)) == n_q;
  assign drop       = (op_q == OP_POP) ? (step_q == pos_q) : head_match;
  assign rem_next   = rem_q + CW'(drop);

  always_comb begin
    ctl      = '0;
    load_idx = ins_q;
    unique case (state_q)
      StIdle: begin
        ctl.load = in_fire && (s_axis_tuser_i == OP_PUSH) && (cnt_q != CW'(DEPTH));
        load_idx = cnt_q[IW-1:0];
      end
      StScan: begin
        ctl = '{shift: 1'b1, load: 1'b1, from_head: 1'b1};
      end
      StCompact: begin
        ctl = '{shift: 1'b1, load: !drop, from_head: 1'b1};
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  klps_chain #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_chain (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .load_idx_i (load_idx),
    .push_ent_i (push_ent),
    .head_ent_o (head_ent)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      op_q    <= '0;
      key_q   <= '0;
      cnt_q   <= '0;
      n_q     <= '0;
      rem_q   <= '0;
      step_q  <= '0;
      ins_q   <= '0;
      pos_q   <= '0;
      found_q <= 1'b0;
      cap_q   <= '0;
      ov_q    <= 1'b0;
      odata_q <= '0;
      ouser_q <= '0;
    end else begin
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            op_q    <= s_axis_tuser_i;
            key_q   <= in_key;
            n_q     <= cnt_q;
            rem_q   <= '0;
            step_q  <= '0;
            ins_q   <= IW'(cnt_q - CW'(1));
            found_q <= 1'b0;
            priority if (s_axis_tuser_i == OP_PUSH) begin
              odata_q <= '0;
              if (cnt_q == CW'(DEPTH)) begin
                ouser_q <= ST_FULL;
              end else begin
                ouser_q <= ST_DONE;
                cnt_q   <= cnt_q + CW'(1);
              end
            end else if (cnt_q == '0) begin
              state_q <= StDone;
            end else if (s_axis_tuser_i == OP_POP) begin
              state_q <= StScan;
            end else if (s_axis_tuser_i == OP_REMOVE) begin
              state_q <= StCompact;
            end else begin
              state_q <= StDone;
            end
          end
        end
        StScan: begin
          if (head_match) begin
            found_q <= 1'b1;
            pos_q   <= step_q;
            cap_q   <= head_ent;
          end
          if (last_step) begin
            step_q  <= '0;
            state_q <= (found_q || head_match) ? StCompact : StDone;
          end else begin
            step_q  <= step_q + IW'(1);
          end
        end
        StCompact: begin
          step_q <= step_q + IW'(1);
          rem_q  <= rem_next;
          if (drop) begin
            ins_q <= ins_q - IW'(1);
          end
          if (last_step) begin
            cnt_q   <= n_q - rem_next;
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_free) begin
            state_q <= StIdle;
            priority if ((op_q == OP_POP) && found_q) begin
              odata_q <= OutDataW'({RemCntW'(1), cap_q.payload, cap_q.key});
              ouser_q <= ST_DONE;
            end else if (op_q == OP_POP) begin
              odata_q <= '0;
              ouser_q <= ST_NOMATCH;
            end else if (op_q == OP_REMOVE) begin
              odata_q <= OutDataW'({RemCntW'(rem_q), {(KeyW + PayW){1'b0}}});
              ouser_q <= ST_DONE;
            end else begin
              odata_q <= '0;
              ouser_q <= ST_DONE;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tuser_o  = ouser_q;

endmodule

`default_nettype wire

[rtl/klps_cell.sv]
// ----------------------------------------------------------------------------
// Keyed LIFO stack cell
// One stack slot: loads a new entry, takes its upper neighbor's, or holds.
// ----------------------------------------------------------------------------
`default_nettype none

module klps_cell (
  input  wire logic            clk_i,
  input  wire logic            shift_i,
  input  wire logic            load_i,
  input  wire klps_pkg::entry_t load_ent_i,
  input  wire klps_pkg::entry_t up_ent_i,
  output klps_pkg::entry_t      ent_o
);
  import klps_pkg::*;

  entry_t ent_q, ent_d;

  always_comb begin
    priority if (load_i) begin
      ent_d = load_ent_i;
    end else if (shift_i) begin
      ent_d = up_ent_i;
    end else begin
      ent_d = ent_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

`default_nettype wire

[rtl/klps_chain.sv]
// ----------------------------------------------------------------------------
// Keyed LIFO stack cell chain
// Row of slots, oldest in cell 0, shifting toward cell 0 one step a cycle while shift is set.
// ----------------------------------------------------------------------------
`default_nettype none

module klps_chain #(
  parameter int unsigned DEPTH = klps_pkg::DefDepth,
  parameter int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk_i,
  input  wire klps_pkg::chain_ctl_t ctl_i,
  input  wire logic [IW-1:0]        load_idx_i,
  input  wire klps_pkg::entry_t     push_ent_i,
  output klps_pkg::entry_t          head_ent_o
);
  import klps_pkg::*;

  entry_t ent[DEPTH];
  entry_t load_ent;

  assign load_ent   = ctl_i.from_head ? ent[0] : push_ent_i;
  assign head_ent_o = ent[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t up_ent;
    logic   load;

    if (i + 1 < DEPTH) begin : g_mid
      assign up_ent = ent[i+1];
    end else begin : g_top
      assign up_ent = ent[i];
    end

    assign load = ctl_i.load && (load_idx_i == IW'(i));

    klps_cell u_cell (
      .clk_i      (clk_i),
      .shift_i    (ctl_i.shift),
      .load_i     (load),
      .load_ent_i (load_ent),
      .up_ent_i   (up_ent),
      .ent_o      (ent[i])
    );
  end

endmodule

`default_nettype wire

[rtl/klps_checker.sv]
// ----------------------------------------------------------------------------
// Keyed LIFO stack port checker
// Checks the result stream of the keyed LIFO stack, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "keyed_lifo_stack_with_purge_top_assert.svh"

module klps_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              m_tvalid_i,
  input wire logic                              m_tready_i,
  input wire logic [klps_pkg::OutDataW-1:0]     m_tdata_i,
  input wire logic [klps_pkg::StatW-1:0]        m_tuser_i
);
  import klps_pkg::*;

  localparam int unsigned EntW = KeyW + PayW;

  `KLPS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i))

  `KLPS_ASSERT_NOW(a_status_code, clk_i, rst_ni, m_tvalid_i, (m_tuser_i == ST_DONE) || (m_tuser_i == ST_NOMATCH) || (m_tuser_i == ST_FULL))

  `KLPS_ASSERT_NOW(a_fail_zero, clk_i, rst_ni, m_tvalid_i && (m_tuser_i != ST_DONE), m_tdata_i == '0)

  `KLPS_ASSERT_NOW(a_pop_count, clk_i, rst_ni, m_tvalid_i && (m_tdata_i[EntW-1:0] != '0), (m_tuser_i == ST_DONE) && (m_tdata_i[EntW+RemCntW-1:EntW] == RemCntW'(1)))

endmodule

bind keyed_lifo_stack_with_purge_top klps_checker u_klps_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o)
);

`default_nettype wire
